// ===== sv/jcc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the joystick channel conditioner.
// No dependencies; imported by jcc_axis_lane, joystick_channel_conditioner and the bench.
package jcc_pkg;

    localparam int unsigned SAMPLE_W  = 12;   // raw stick sample
    localparam int unsigned SCL_W     = 11;   // scaled stick, 1000..1999
    localparam int unsigned SUM_W     = 17;   // calibration sum
    localparam int unsigned OFF_W     = 11;   // centre offset
    localparam int unsigned CNT_W     = 6;    // calibration scan count
    localparam int unsigned VAL_W     = 16;   // axis working width
    localparam int unsigned THR_W     = 10;
    localparam int unsigned KEY_W     = 8;
    localparam int unsigned SEQ_W     = 8;
    localparam int unsigned NLANES    = 3;    // yaw, roll, pitch
    localparam int unsigned NSTAGES   = 5;
    localparam int unsigned S_DATA_W  = 56;
    localparam int unsigned M_DATA_W  = 64;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam int unsigned CAL_SAMPLES_DEF = 60;

    // Calibration trigger and centring window
    localparam logic [SAMPLE_W-1:0] TRIG_LEVEL = 12'd4090;
    localparam logic [SAMPLE_W-1:0] WIN_LO     = 12'd1900;
    localparam logic [SAMPLE_W-1:0] WIN_HI     = 12'd2196;
    localparam logic [SEQ_W-1:0]    SEQ_LAST   = 8'd200;
    localparam logic [VAL_W-1:0]    CENTRE     = 16'd1500;

    // Register map, indexed by paddr[3:2]
    localparam logic [1:0] REG_DB_LOW  = 2'd0;
    localparam logic [1:0] REG_DB_HIGH = 2'd1;
    localparam logic [1:0] REG_CLAMP_MIN = 2'd2;
    localparam logic [1:0] REG_CLAMP_MAX = 2'd3;

    localparam logic [SAMPLE_W-1:0] DB_LOW_RST    = 12'd1470;
    localparam logic [SAMPLE_W-1:0] DB_HIGH_RST   = 12'd1530;
    localparam logic [SAMPLE_W-1:0] CLAMP_MIN_RST = 12'd1100;
    localparam logic [SAMPLE_W-1:0] CLAMP_MAX_RST = 12'd1900;

    typedef struct packed {
        logic [SAMPLE_W-1:0] db_low;
        logic [SAMPLE_W-1:0] db_high;
        logic [SAMPLE_W-1:0] clamp_min;
        logic [SAMPLE_W-1:0] clamp_max;
    } t_cfg;

    // Load strobes for one axis lane
    typedef struct packed {
        logic ld_s2;    // scaled value and product into stage 2
        logic ld_s3;    // scaled value into stage 3
        logic ld_off;   // new centre offset from finished calibration
        logic ld_mid;   // first half of conditioning
        logic ld_out;   // output register
    } t_lane_ctl;

    // Fields that ride alongside the lanes
    typedef struct packed {
        logic [THR_W-1:0] throttle;
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] seq;
        logic             cal;
    } t_side;

    // 1000 + v*1000/4096
    function automatic logic [SCL_W-1:0] scale_stick(input logic [SAMPLE_W-1:0] v);
        logic [21:0] p;
        p = {10'd0, v} * 22'd1000;
        return SCL_W'(p[21:12]) + 11'd1000;
    endfunction

    // (4096 - v)*1000/4096
    function automatic logic [THR_W-1:0] throttle_of(input logic [SAMPLE_W-1:0] v);
        logic [12:0] d;
        logic [22:0] p;
        d = 13'd4096 - {1'b0, v};
        p = {10'd0, d} * 23'd1000;
        return p[21:12];
    endfunction

endpackage

// ===== sv/jcc_axis_lane.sv =====
// One axis lane: centre offset division, offset removal, deadband and clamp.
// Depends on jcc_pkg; instantiated three times by joystick_channel_conditioner.
module jcc_axis_lane #(
    parameter int unsigned CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jcc_pkg::t_lane_ctl            i_ctl,
    input  jcc_pkg::t_cfg                 i_cfg,
    input  logic [jcc_pkg::SCL_W-1:0]     i_scl,   // scaled sample from stage 1
    input  logic [jcc_pkg::SUM_W-1:0]     i_sum,   // running calibration sum
    output logic [jcc_pkg::SAMPLE_W-1:0]  o_axis
);
    import jcc_pkg::*;

    // Exact division by reciprocal: floor(n*M / 2^SH) for any n below 2^SUM_W
    localparam int unsigned DIV_L   = $clog2(CAL_SAMPLES);
    localparam int unsigned DIV_SH  = SUM_W + DIV_L;
    localparam longint unsigned DIV_M_L =
        ((64'd1 << DIV_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [SUM_W:0] DIV_M = DIV_M_L[SUM_W:0];
    localparam int unsigned PROD_W  = 2 * SUM_W + 1;

    logic [SCL_W-1:0]  r_s2, r_s3;
    logic [PROD_W-1:0] r_prod;
    logic [OFF_W-1:0]  r_off;
    logic [VAL_W-1:0]  r_mid;
    logic [SAMPLE_W-1:0] r_out;

    logic [VAL_W-1:0] n_mid, n_val;
    logic [VAL_W-1:0] db_lo, db_hi, c_min, c_max, shift;
    logic [VAL_W-1:0] v0, v1, v3, v4;

    assign db_lo = {4'd0, i_cfg.db_low};
    assign db_hi = {4'd0, i_cfg.db_high};
    assign c_min = {4'd0, i_cfg.clamp_min};
    assign c_max = {4'd0, i_cfg.clamp_max};
    assign shift = CENTRE - db_lo;

    // Stage 2: product of sum and reciprocal; scaled value into stages 2 and 3
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_s2) begin
            r_s2   <= i_scl;
            r_prod <= {{(SUM_W+1){1'b0}}, i_sum} * {{SUM_W{1'b0}}, DIV_M};
        end
        if (i_ctl.ld_s3) begin
            r_s3 <= r_s2;
        end
    end

    // Centre offset, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (i_ctl.ld_off) begin
            r_off <= r_prod[DIV_SH +: OFF_W];
        end
    end

    // First half: remove offset, snap to centre, lift low side
    always_comb begin
        v0 = CENTRE + VAL_W'(r_s3) - VAL_W'(r_off);
        if (v0 > db_lo && v0 < db_hi) begin
            v1 = CENTRE;
        end else begin
            v1 = v0;
        end
        if (v1 < db_lo) begin
            n_mid = v1 + shift;
        end else begin
            n_mid = v1;
        end
    end

    // Second half: drop high side, then clamp
    always_comb begin
        if (r_mid > db_hi) begin
            v3 = r_mid - shift;
        end else begin
            v3 = r_mid;
        end
        if (v3 <= c_min) begin
            v4 = c_min;
        end else begin
            v4 = v3;
        end
        if (v4 >= c_max) begin
            n_val = c_max;
        end else begin
            n_val = v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mid) begin
            r_mid <= n_mid;
        end
        if (i_ctl.ld_out) begin
            r_out <= n_val[SAMPLE_W-1:0];
        end
    end

    assign o_axis = r_out;

endmodule

// ===== sv/joystick_channel_conditioner.sv =====
// Top level of the joystick channel conditioner: stream ports, APB registers,
// calibration control and the three axis lanes. Depends on jcc_pkg, jcc_axis_lane.
//
// One scan word in, one packet word out, one scan per clock when the output side
// keeps taking. The word passes through scale and calibration update, reciprocal
// multiply for the centre offset, then offset removal, deadband and clamp, then
// the output register. Every stage has its own valid bit and moves when the stage
// after it is free, so the input keeps accepting while a finished word waits
// until every stage is full. Holding both the throttle stick and the pitch stick
// near full scale starts centre calibration; the next CAL_SAMPLES scans with roll
// and pitch centred are averaged into the yaw, roll and pitch offsets, and the
// packet carrying the last of them already uses the new offsets. Offsets are zero
// after reset, so the axes sit at a clamp until a calibration has completed.
// Registers must be written only while no scan is in flight.
module joystick_channel_conditioner #(
    parameter int unsigned CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // left_x[11:0], left_y[23:12], right_x[35:24], right_y[47:36], unlock_key[55:48]
    input  logic [jcc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // yaw_out[11:0], throttle_out[21:12], roll_out[33:22], pitch_out[45:34],
    // unlock_out[53:46], sequence_id[61:54], zero[63:62]
    output logic [jcc_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // calibrating[0]
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [jcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [jcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import jcc_pkg::*;

    // Configuration registers
    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.db_low    <= DB_LOW_RST;
            r_cfg.db_high   <= DB_HIGH_RST;
            r_cfg.clamp_min <= CLAMP_MIN_RST;
            r_cfg.clamp_max <= CLAMP_MAX_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DB_LOW:    r_cfg.db_low    <= pwdata[SAMPLE_W-1:0];
                REG_DB_HIGH:   r_cfg.db_high   <= pwdata[SAMPLE_W-1:0];
                REG_CLAMP_MIN: r_cfg.clamp_min <= pwdata[SAMPLE_W-1:0];
                REG_CLAMP_MAX: r_cfg.clamp_max <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DB_LOW:    prdata = {20'd0, r_cfg.db_low};
            REG_DB_HIGH:   prdata = {20'd0, r_cfg.db_high};
            REG_CLAMP_MIN: prdata = {20'd0, r_cfg.clamp_min};
            REG_CLAMP_MAX: prdata = {20'd0, r_cfg.clamp_max};
            default:       prdata = '0;
        endcase
    end

    // Pipeline flow: a stage loads when it is empty or its word moves on
    logic [NSTAGES-1:0] r_vld;
    logic [NSTAGES-1:0] en;
    logic               acc;

    always_comb begin
        en[NSTAGES-1] = !r_vld[NSTAGES-1] || m_axis_tready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign acc           = s_axis_tvalid && en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Unpack the scan word
    logic [SAMPLE_W-1:0] lx, ly, rx, ry;
    logic [KEY_W-1:0]    key;
    logic [SCL_W-1:0]    scl [NLANES];

    assign lx  = s_axis_tdata[11:0];
    assign ly  = s_axis_tdata[23:12];
    assign rx  = s_axis_tdata[35:24];
    assign ry  = s_axis_tdata[47:36];
    assign key = s_axis_tdata[55:48];

    assign scl[0] = scale_stick(lx);
    assign scl[1] = scale_stick(rx);
    assign scl[2] = scale_stick(ry);

    // Calibration state and sequence counter
    logic                r_cal_mode;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_sum [NLANES];
    logic [SEQ_W-1:0]    r_seq;

    logic                n_cal_mode;
    logic [CNT_W-1:0]    n_cnt;
    logic [SUM_W-1:0]    n_sum [NLANES];
    logic [SEQ_W-1:0]    n_seq;
    logic                trig, in_win, take, fin;
    logic [CNT_W:0]      cnt_inc;

    always_comb begin
        trig    = (ry > TRIG_LEVEL) && (ly > TRIG_LEVEL);
        in_win  = (rx > WIN_LO) && (rx < WIN_HI) && (ry > WIN_LO) && (ry < WIN_HI);
        take    = (r_cal_mode || trig) && in_win;
        cnt_inc = {1'b0, r_cnt} + 1'b1;
        fin     = take && (cnt_inc >= (CNT_W+1)'(CAL_SAMPLES));

        n_cal_mode = (r_cal_mode || trig) && !fin;
        n_cnt      = r_cnt;
        if (take) begin
            n_cnt = fin ? '0 : cnt_inc[CNT_W-1:0];
        end
        for (int k = 0; k < NLANES; k++) begin
            n_sum[k] = r_sum[k];
            if (take) begin
                n_sum[k] = ((r_cnt == '0) ? '0 : r_sum[k]) + SUM_W'(scl[k]);
            end
        end

        n_seq = (r_seq > SEQ_LAST) ? '0 : r_seq + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_mode <= 1'b0;
            r_cnt      <= '0;
            r_seq      <= '0;
        end else if (acc) begin
            r_cal_mode <= n_cal_mode;
            r_cnt      <= n_cnt;
            r_seq      <= n_seq;
        end
    end

    // Sums are cleared by the first centred scan, so they need no reset
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int k = 0; k < NLANES; k++) begin
                r_sum[k] <= n_sum[k];
            end
        end
    end

    // Stage 1 payload and side fields down the pipe
    logic [SCL_W-1:0] r_scl [NLANES];
    logic             r_fin;
    t_side            r_side [NSTAGES];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < NLANES; k++) begin
                r_scl[k] <= scl[k];
            end
            r_fin             <= fin;
            r_side[0].throttle <= throttle_of(ly);
            r_side[0].key      <= key;
            r_side[0].seq      <= n_seq;
            r_side[0].cal      <= n_cal_mode;
        end
        for (int k = 1; k < NSTAGES; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Finish flag travels with its word into stage 2
    logic r_fin_s2;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_fin_s2 <= r_fin;
        end
    end

    // Axis lanes
    t_lane_ctl lane_ctl;
    logic [SAMPLE_W-1:0] axis [NLANES];

    assign lane_ctl.ld_s2  = en[1];
    assign lane_ctl.ld_s3  = en[2];
    assign lane_ctl.ld_off = en[2] && r_vld[1] && r_fin_s2;
    assign lane_ctl.ld_mid = en[3];
    assign lane_ctl.ld_out = en[4];

    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        jcc_axis_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_cfg   (r_cfg),
            .i_scl   (r_scl[g]),
            .i_sum   (r_sum[g]),
            .o_axis  (axis[g])
        );
    end

    // Merge lanes and side fields into the packet word
    assign m_axis_tvalid = r_vld[NSTAGES-1];
    assign m_axis_tdata  = {2'b00,
                            r_side[NSTAGES-1].seq,
                            r_side[NSTAGES-1].key,
                            axis[2],
                            axis[1],
                            r_side[NSTAGES-1].throttle,
                            axis[0]};
    assign m_axis_tuser  = r_side[NSTAGES-1].cal;

endmodule

// ===== bench/packet_checker.sv =====
// Packet checker for the joystick channel conditioner bench: predicts each packet word
// from the scan words and register writes it sees, and compares. Depends on jcc_pkg.
module packet_checker #(
    parameter int unsigned CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // scan channel
    input  logic [jcc_pkg::S_DATA_W-1:0]  i_scan_data,
    input  logic                          i_scan_valid,
    input  logic                          i_scan_ready,
    // packet channel
    input  logic [jcc_pkg::M_DATA_W-1:0]  i_pkt_data,
    input  logic [0:0]                    i_pkt_user,
    input  logic                          i_pkt_valid,
    input  logic                          i_pkt_ready,
    // register bus
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [jcc_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [jcc_pkg::PDATA_W-1:0]   i_pwdata,
    input  logic                          i_pready,
    output int unsigned                   o_mismatches,
    output int unsigned                   o_outstanding,
    output int unsigned                   o_checked,
    output int unsigned                   o_calibrations
);
    timeunit 1ns;
    timeprecision 1ps;
    import jcc_pkg::*;

    localparam logic [15:0] CENTRE_VALUE  = 16'd1500;
    localparam logic [11:0] TRIGGER_ABOVE = 12'd4090;
    localparam logic [11:0] WINDOW_LO     = 12'd1900;   // exclusive
    localparam logic [11:0] WINDOW_HI     = 12'd2196;   // exclusive
    localparam logic [7:0]  SEQ_TOP       = 8'd200;

    typedef struct packed {
        logic [11:0] yaw;
        logic [9:0]  throttle;
        logic [11:0] roll;
        logic [11:0] pitch;
        logic [7:0]  unlock;
        logic [7:0]  seq;
        logic [1:0]  pad;
        logic        cal;
    } packet_t;

    // predicted block state
    t_cfg              cfg;
    logic              cal_mode;
    logic [CNT_W-1:0]  cal_count;
    logic [SUM_W-1:0]  cal_sum [NLANES];
    logic [OFF_W-1:0]  centre [NLANES];
    logic [SEQ_W-1:0]  seq_no;
    packet_t           packets_due [$];

    int unsigned mismatches;
    int unsigned checked;
    int unsigned calibrations;

    // 1000 + v*1000/4096
    function automatic logic [10:0] stick_scaled(input logic [11:0] raw);
        logic [31:0] prod;
        prod = 32'(raw) * 32'd1000;
        return 11'(32'd1000 + prod / 32'd4096);
    endfunction

    // offset removal, deadband shift and clamp, all in 16 bits
    function automatic logic [11:0] shape_axis(input logic [11:0] raw,
                                               input logic [10:0] centre_off);
        logic [15:0] v, shift, lo, hi, cmin, cmax;
        lo    = 16'(cfg.db_low);
        hi    = 16'(cfg.db_high);
        cmin  = 16'(cfg.clamp_min);
        cmax  = 16'(cfg.clamp_max);
        v     = CENTRE_VALUE + 16'(stick_scaled(raw)) - 16'(centre_off);
        shift = CENTRE_VALUE - lo;
        if (v > lo && v < hi) v = CENTRE_VALUE;
        if (v < lo) v = v + shift;
        if (v > hi) v = v - shift;
        if (v <= cmin) v = cmin;
        if (v >= cmax) v = cmax;
        return v[11:0];
    endfunction

    function automatic logic [9:0] throttle_scaled(input logic [11:0] raw);
        logic [31:0] t;
        t = (32'd4096 - 32'(raw)) * 32'd1000 / 32'd4096;
        return t[9:0];
    endfunction

    // one scan: trigger check, calibration sample, then the packet
    task automatic predict_packet(input logic [S_DATA_W-1:0] word, output packet_t pkt);
        logic [11:0] lane_raw [NLANES];
        logic [11:0] ly, ry;
        lane_raw[0] = word[11:0];
        ly          = word[23:12];
        lane_raw[1] = word[35:24];
        lane_raw[2] = word[47:36];
        ry          = lane_raw[2];

        if (ry > TRIGGER_ABOVE && ly > TRIGGER_ABOVE) cal_mode = 1'b1;

        if (cal_mode && lane_raw[1] > WINDOW_LO && lane_raw[1] < WINDOW_HI
                && ry > WINDOW_LO && ry < WINDOW_HI) begin
            for (int k = 0; k < NLANES; k++) begin
                if (cal_count == '0) cal_sum[k] = '0;
                cal_sum[k] = SUM_W'(cal_sum[k] + stick_scaled(lane_raw[k]));
            end
            cal_count = cal_count + 1'b1;
            if (cal_count >= CAL_SAMPLES) begin
                for (int k = 0; k < NLANES; k++)
                    centre[k] = OFF_W'(cal_sum[k] / cal_count);
                cal_mode  = 1'b0;
                cal_count = '0;
                calibrations++;
            end
        end

        if (seq_no > SEQ_TOP) seq_no = '0;
        else seq_no = seq_no + 1'b1;

        pkt.yaw      = shape_axis(lane_raw[0], centre[0]);
        pkt.throttle = throttle_scaled(ly);
        pkt.roll     = shape_axis(lane_raw[1], centre[1]);
        pkt.pitch    = shape_axis(lane_raw[2], centre[2]);
        pkt.unlock   = word[55:48];
        pkt.seq      = seq_no;
        pkt.pad      = '0;
        pkt.cal      = cal_mode;
    endtask

    task automatic compare_field(input string field, input logic [11:0] want,
                                 input logic [11:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("packet %0d %s: expected %0d, got %0d", checked, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        packet_t want, got;
        if (!i_rst_n) begin
            cfg.db_low    = 12'd1470;
            cfg.db_high   = 12'd1530;
            cfg.clamp_min = 12'd1100;
            cfg.clamp_max = 12'd1900;
            cal_mode      = 1'b0;
            cal_count     = '0;
            seq_no        = '0;
            for (int k = 0; k < NLANES; k++) begin
                cal_sum[k] = '0;
                centre[k]  = '0;
            end
            packets_due.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_DB_LOW:    cfg.db_low    = i_pwdata[11:0];
                    REG_DB_HIGH:   cfg.db_high   = i_pwdata[11:0];
                    REG_CLAMP_MIN: cfg.clamp_min = i_pwdata[11:0];
                    REG_CLAMP_MAX: cfg.clamp_max = i_pwdata[11:0];
                    default: ;
                endcase
            end

            // scan word accepted
            if (i_scan_valid && i_scan_ready) begin
                predict_packet(i_scan_data, want);
                packets_due.push_back(want);
            end

            // packet word accepted
            if (i_pkt_valid && i_pkt_ready) begin
                if (packets_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("packet word %h arrived with nothing predicted", i_pkt_data);
                    mismatches++;
                end else begin
                    want         = packets_due.pop_front();
                    got.yaw      = i_pkt_data[11:0];
                    got.throttle = i_pkt_data[21:12];
                    got.roll     = i_pkt_data[33:22];
                    got.pitch    = i_pkt_data[45:34];
                    got.unlock   = i_pkt_data[53:46];
                    got.seq      = i_pkt_data[61:54];
                    got.pad      = i_pkt_data[63:62];
                    got.cal      = i_pkt_user[0];
                    compare_field("yaw", want.yaw, got.yaw);
                    compare_field("throttle", 12'(want.throttle), 12'(got.throttle));
                    compare_field("roll", want.roll, got.roll);
                    compare_field("pitch", want.pitch, got.pitch);
                    compare_field("unlock", 12'(want.unlock), 12'(got.unlock));
                    compare_field("sequence", 12'(want.seq), 12'(got.seq));
                    compare_field("padding", 12'(want.pad), 12'(got.pad));
                    compare_field("calibrating", 12'(want.cal), 12'(got.cal));
                    checked++;
                end
            end
        end
        o_mismatches   <= mismatches;
        o_outstanding  <= packets_due.size();
        o_checked      <= checked;
        o_calibrations <= calibrations;
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the joystick channel conditioner bench: clock, reset, scan and register
// stimulus, packet-side back-pressure and the verdict. Depends on jcc_pkg,
// packet_checker and joystick_channel_conditioner.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jcc_pkg::*;

    localparam int unsigned CAL_SCANS = CAL_SAMPLES_DEF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int unsigned mismatches, outstanding, checked, calibrations;

    // sender and receiver pacing
    int unsigned burst_left = 0;
    int unsigned gap_max = 0;
    bit          stall_on = 1'b0;
    int unsigned hold_off_cycles = 0;
    logic [15:0] stall_mask = '1;
    int unsigned mask_bit = 0;
    int unsigned scans_sent = 0;
    int unsigned settings_used = 1;

    joystick_channel_conditioner #(.CAL_SAMPLES(CAL_SCANS)) i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    packet_checker #(.CAL_SAMPLES(CAL_SCANS)) i_checker (
        .i_clk, .i_rst_n,
        .i_scan_data(s_axis_tdata), .i_scan_valid(s_axis_tvalid),
        .i_scan_ready(s_axis_tready),
        .i_pkt_data(m_axis_tdata), .i_pkt_user(m_axis_tuser),
        .i_pkt_valid(m_axis_tvalid), .i_pkt_ready(m_axis_tready),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_mismatches(mismatches), .o_outstanding(outstanding),
        .o_checked(checked), .o_calibrations(calibrations)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // packet side: always ready, a shifting stall mask, or a long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end else if (stall_on) begin
                if (mask_bit == 0) stall_mask = 16'($urandom);
                m_axis_tready <= stall_mask[mask_bit];
                mask_bit = (mask_bit + 1) % 16;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one scan word, with a random gap at the start of each burst
    task automatic offer_scan(input logic [11:0] lx, input logic [11:0] ly,
                              input logic [11:0] rx, input logic [11:0] ry,
                              input logic [7:0] key);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {key, ry, rx, ly, lx};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        scans_sent++;
    endtask

    // stop offering and wait for every predicted packet to come out
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [11:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {20'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [11:0] db_lo, input logic [11:0] db_hi,
                                  input logic [11:0] c_min, input logic [11:0] c_max);
        wait_drained();
        write_register(REG_DB_LOW, db_lo);
        write_register(REG_DB_HIGH, db_hi);
        write_register(REG_CLAMP_MIN, c_min);
        write_register(REG_CLAMP_MAX, c_max);
        settings_used++;
    endtask

    // stick value: mostly near centre so the deadband edges get hit
    function automatic logic [11:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 12'($urandom);
            1: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return 12'($urandom_range(1848, 2248));
        endcase
    endfunction

    // value inside the centring window, edges now and then
    function automatic logic [11:0] window_sample();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 12'd2195 : 12'd1901;
        return 12'($urandom_range(1901, 2195));
    endfunction

    task automatic random_scan();
        logic [11:0] ly, ry;
        ly = 12'($urandom);
        ry = pick_axis();
        // stray calibration trigger
        if ($urandom_range(0, 24) == 0) begin
            ly = 12'($urandom_range(4091, 4095));
            ry = 12'($urandom_range(4091, 4095));
        end
        offer_scan(pick_axis(), ly, pick_axis(), ry, 8'($urandom));
    endtask

    // trigger, then a full set of centred scans with the odd stray one between
    task automatic calibration_run();
        int unsigned placed;
        offer_scan(pick_axis(), 12'($urandom_range(4091, 4095)), pick_axis(),
                   12'($urandom_range(4091, 4095)), 8'($urandom));
        placed = 0;
        while (placed < CAL_SCANS) begin
            if ($urandom_range(0, 9) == 0) begin
                random_scan();
            end else begin
                offer_scan(pick_axis(), 12'($urandom), window_sample(), window_sample(),
                           8'($urandom));
                placed++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, offsets still zero
        gap_max  = 3;
        stall_on = 1'b1;
        offer_scan(12'h000, 12'h000, 12'h000, 12'h000, 8'h00);
        offer_scan(12'hFFF, 12'h000, 12'hFFF, 12'h000, 8'hFF);
        offer_scan(12'd2048, 12'hFFF, 12'd2048, 12'd2048, 8'hA5);
        offer_scan(12'd2048, 12'd4090, 12'd2048, 12'd4095, 8'h5A);   // throttle edge, no trigger
        offer_scan(12'd2048, 12'd4091, 12'd2048, 12'd4090, 8'h01);   // pitch edge, no trigger
        offer_scan(12'd2048, 12'd4091, 12'd2000, 12'd4091, 8'h80);   // trigger
        offer_scan(12'd1000, 12'd2048, 12'd1900, 12'd2000, 8'h7F);   // roll just outside
        offer_scan(12'd3000, 12'd2048, 12'd1901, 12'd1901, 8'hFE);   // lowest window value
        offer_scan(12'hFFF, 12'd100, 12'd2195, 12'd2195, 8'h33);     // highest window value
        offer_scan(12'd2048, 12'd2048, 12'd2196, 12'd2000, 8'hCC);   // roll just outside
        offer_scan(12'd2048, 12'd2048, 12'd2000, 12'd2196, 8'h0F);   // pitch just outside
        offer_scan(12'd2048, 12'hFFF, 12'd2048, 12'hFFF, 8'hF0);     // trigger while calibrating
        offer_scan(12'h000, 12'd3000, 12'd2048, 12'd2048, 8'h3C);
        offer_scan(12'hFFF, 12'd1, 12'd2048, 12'd2048, 8'hC3);

        // random phases, each with its own settings and pacing
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: apply_settings(12'($urandom_range(1300, 1499)), 12'($urandom_range(1501, 1700)),
                                  12'($urandom_range(900, 1400)), 12'($urandom_range(1600, 2100)));
                2: apply_settings(12'h000, 12'hFFF, 12'h000, 12'hFFF);
                3: apply_settings(12'hFFF, 12'h000, 12'hFFF, 12'h000);
                4: apply_settings(12'($urandom_range(1501, 2500)), 12'($urandom),
                                  12'($urandom_range(0, 1500)), 12'($urandom_range(1500, 4095)));
                5: apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                default: ;
            endcase
            gap_max  = (phase == 1 || phase == 4) ? 0 : 2 * phase + 2;
            stall_on = (phase != 1 && phase != 3);

            calibration_run();

            // long hold-off on the packet side while scans keep coming
            if (phase == 1) begin
                hold_off_cycles = 80;
                repeat (30) random_scan();
                wait_drained();
            end
            repeat (35) random_scan();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d scans over %0d register settings: %0d packets checked,",
                 scans_sent, settings_used, checked);
        $display("%0d centre calibrations completed, sequence number wrapped %0d times.",
                 calibrations, scans_sent / 202);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Timed out with %0d packets still predicted", outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
sv/jcc_pkg.sv
sv/jcc_axis_lane.sv
sv/joystick_channel_conditioner.sv
bench/packet_checker.sv
bench/testbench.sv
